FILE: rtl/ldt_pkg.sv
package ldt_pkg;

    localparam int TABLE_ENTRIES = 8192;
    localparam int MAX_READ      = 64;
    localparam int ENTRY_W       = 13;
    localparam int CNT_W         = 7;
    localparam int DESC_W        = 64;
    localparam int WRITE_BYTES   = 16;
    localparam int S_DATA_W      = 104;
    localparam int M_DATA_W      = 96;

    typedef enum logic [1:0] {
        REQ_READ      = 2'd0,
        REQ_WR_LEGACY = 2'd1,
        REQ_WR_EXT    = 2'd2,
        REQ_UNSUP     = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_NOSYS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RESP  = 2'd2
    } cmd_op_t;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_DATA  = 2'd2
    } back_state_t;

    typedef struct packed {
        cmd_op_t              op;
        status_t              status;
        logic [ENTRY_W-1:0]   entry;
        logic [CNT_W-1:0]     count;
        logic [DESC_W-1:0]    wdata;
    } cmd_t;

endpackage

FILE: rtl/ldt_descriptor_table.sv
// Table of 8192 x86 segment descriptors with a request stream in and a result
// stream out. After reset the table is swept to zero, one entry per cycle, so
// no item is taken until the sweep is done. Requests are decoded in the front
// and queued two deep; the back end owns the single-port table. A write, an
// error or an empty read gives one result, valid in the cycle after the back
// end pops it. A read gives one result per descriptor: the first is read into
// a register and then into the output register; the rest follow one per cycle
// while m_axis_tready stays high, limited by the one port and registered read.
module ldt_descriptor_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // byte_count, entry_index, base_address, seg_limit, contents,
    // rx_only, def_big, gran_4k, not_present, useable
    input  logic [ldt_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // descriptor, result_entry, bytes_done
    output logic [ldt_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // status
    output logic [1:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);
    import ldt_pkg::*;

    cmd_t               front_cmd;
    cmd_t               q_head;
    logic               q_empty;
    logic               q_full;
    logic               q_pop;
    logic               push;
    logic               init_done;
    logic [DESC_W-1:0]  out_desc;
    logic [ENTRY_W-1:0] out_entry;
    logic [15:0]        out_bytes;

    assign s_axis_tready = init_done && !q_full;
    assign push          = s_axis_tvalid && s_axis_tready;

    ldt_front u_front (
        .req_type  (s_axis_tuser),
        .item_data (s_axis_tdata),
        .cmd       (front_cmd)
    );

    ldt_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_cmd),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    ldt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (q_head),
        .cmd_valid  (!q_empty),
        .cmd_pop    (q_pop),
        .init_done  (init_done),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_desc   (out_desc),
        .out_entry  (out_entry),
        .out_bytes  (out_bytes),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, out_bytes, out_entry, out_desc};

endmodule

FILE: rtl/ldt_front.sv
module ldt_front (
    input  logic [1:0]                   req_type,
    input  logic [ldt_pkg::S_DATA_W-1:0] item_data,
    output ldt_pkg::cmd_t                cmd
);
    import ldt_pkg::*;

    logic [15:0] byte_count;
    logic [15:0] entry_index;
    logic [31:0] base_address;
    logic [31:0] seg_limit;
    logic [1:0]  contents;
    logic        rx_only;
    logic        def_big;
    logic        gran_4k;
    logic        not_present;
    logic        useable;

    logic        legacy;
    logic        idx_ok;
    logic [13:0] want;
    logic [CNT_W-1:0] want_c;
    logic [13:0] avail;
    logic [13:0] n_rd;
    logic        bad_wr;
    logic        empty_seg;
    logic        do_clear;
    logic [DESC_W-1:0] packed_desc;

    assign byte_count   = item_data[15:0];
    assign entry_index  = item_data[31:16];
    assign base_address = item_data[63:32];
    assign seg_limit    = item_data[95:64];
    assign contents     = item_data[97:96];
    assign rx_only      = item_data[98];
    assign def_big      = item_data[99];
    assign gran_4k      = item_data[100];
    assign not_present  = item_data[101];
    assign useable      = item_data[102];

    assign legacy = (req_t'(req_type) == REQ_WR_LEGACY);
    assign idx_ok = ({1'b0, entry_index} < 17'(TABLE_ENTRIES));

    // entries wanted: ceil(bytes / 8), clamped
    assign want   = 14'((17'(byte_count) + 17'd7) >> 3);
    assign want_c = (want > 14'(MAX_READ)) ? CNT_W'(MAX_READ) : CNT_W'(want);
    assign avail  = idx_ok ? 14'(17'(TABLE_ENTRIES) - {1'b0, entry_index}) : 14'd0;
    assign n_rd   = (14'(want_c) < avail) ? 14'(want_c) : avail;

    assign bad_wr = (byte_count != 16'(WRITE_BYTES)) || !idx_ok ||
                    ((contents == 2'd3) && (legacy || !not_present));
    assign empty_seg = (contents == 2'd0) && rx_only && !def_big &&
                       !gran_4k && not_present && !useable;
    assign do_clear  = (base_address == 32'd0) && (seg_limit == 32'd0) &&
                       (legacy || empty_seg);

    assign packed_desc = {base_address[31:24], gran_4k, def_big, 1'b0,
                          (useable & ~legacy), seg_limit[19:16], ~not_present,
                          2'b11, 1'b1, contents, ~rx_only, 1'b0,
                          base_address[23:0], seg_limit[15:0]};

    always_comb begin
        cmd.op     = OP_RESP;
        cmd.status = ST_OK;
        cmd.entry  = entry_index[ENTRY_W-1:0];
        cmd.count  = '0;
        cmd.wdata  = '0;
        unique case (req_t'(req_type))
            REQ_READ: begin
                if (n_rd != 14'd0) begin
                    cmd.op    = OP_READ;
                    cmd.count = CNT_W'(n_rd);
                end
            end
            REQ_WR_LEGACY, REQ_WR_EXT: begin
                if (bad_wr) begin
                    cmd.status = ST_INVAL;
                end else begin
                    cmd.op    = OP_WRITE;
                    cmd.wdata = do_clear ? '0 : packed_desc;
                end
            end
            REQ_UNSUP: begin
                cmd.status = ST_NOSYS;
            end
        endcase
    end

endmodule

FILE: rtl/ldt_cmd_fifo.sv
module ldt_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ldt_pkg::cmd_t push_data,
    input  logic          pop,
    output ldt_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import ldt_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/ldt_back.sv
module ldt_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ldt_pkg::cmd_t            cmd,
    input  logic                     cmd_valid,
    output logic                     cmd_pop,
    output logic                     init_done,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               out_status,
    output logic [ldt_pkg::DESC_W-1:0]  out_desc,
    output logic [ldt_pkg::ENTRY_W-1:0] out_entry,
    output logic [15:0]              out_bytes,
    output logic                     out_last
);
    import ldt_pkg::*;

    logic [DESC_W-1:0] table_mem [TABLE_ENTRIES];
    logic [DESC_W-1:0] rd_data_reg;

    back_state_t state_reg, state_next;

    logic [ENTRY_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ENTRY_W-1:0] rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0]   rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]   rd_done_reg, rd_done_next;
    logic [CNT_W-1:0]   done_inc;
    logic               rd_last;

    logic               out_free;
    logic               mem_we;
    logic [ENTRY_W-1:0] mem_waddr;
    logic [DESC_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [ENTRY_W-1:0] mem_raddr;

    logic               out_load;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [DESC_W-1:0]  m_desc_reg, m_desc_next;
    logic [ENTRY_W-1:0] m_entry_reg, m_entry_next;
    logic [15:0]        m_bytes_reg, m_bytes_next;
    logic               m_last_reg, m_last_next;

    assign out_free  = !m_valid_reg || out_ready;
    assign done_inc  = rd_done_reg + CNT_W'(1);
    assign rd_last   = (done_inc == rd_cnt_reg);
    assign init_done = (state_reg != BK_CLEAR);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR: begin
                if (clr_cnt_reg == ENTRY_W'(TABLE_ENTRIES - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (cmd_valid && out_free && cmd.op == OP_READ) begin
                    state_next = BK_DATA;
                end
            end
            BK_DATA: begin
                if (out_free && rd_last) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cmd.entry;
        mem_wdata     = cmd.wdata;
        mem_re        = 1'b0;
        mem_raddr     = cmd.entry;
        out_load      = 1'b0;
        clr_cnt_next  = clr_cnt_reg;
        rd_addr_next  = rd_addr_reg;
        rd_cnt_next   = rd_cnt_reg;
        rd_done_next  = rd_done_reg;
        m_status_next = cmd.status;
        m_desc_next   = '0;
        m_entry_next  = cmd.entry;
        m_bytes_next  = '0;
        m_last_next   = 1'b1;
        unique case (state_reg)
            BK_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + ENTRY_W'(1);
            end
            BK_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_READ: begin
                            mem_re       = 1'b1;
                            rd_addr_next = cmd.entry;
                            rd_cnt_next  = cmd.count;
                            rd_done_next = '0;
                        end
                        OP_WRITE: begin
                            mem_we   = 1'b1;
                            out_load = 1'b1;
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            BK_DATA: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_status_next = ST_OK;
                    m_desc_next   = rd_data_reg;
                    m_entry_next  = rd_addr_reg;
                    m_bytes_next  = {6'd0, done_inc, 3'd0};
                    m_last_next   = rd_last;
                    rd_done_next  = done_inc;
                    if (!rd_last) begin
                        mem_re       = 1'b1;
                        mem_raddr    = rd_addr_reg + ENTRY_W'(1);
                        rd_addr_next = rd_addr_reg + ENTRY_W'(1);
                    end
                end
            end
            default: ;
        endcase
        m_valid_next = out_load || (m_valid_reg && !out_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        rd_cnt_reg  <= rd_cnt_next;
        rd_done_reg <= rd_done_next;
        if (out_load) begin
            m_status_reg <= m_status_next;
            m_desc_reg   <= m_desc_next;
            m_entry_reg  <= m_entry_next;
            m_bytes_reg  <= m_bytes_next;
            m_last_reg   <= m_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= table_mem[mem_raddr];
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_desc   = m_desc_reg;
    assign out_entry  = m_entry_reg;
    assign out_bytes  = m_bytes_reg;
    assign out_last   = m_last_reg;

endmodule

FILE: sim/tb_ldt_descriptor_table.sv
`timescale 1ns / 100ps

module tb_ldt_descriptor_table;
    import ldt_pkg::*;

    localparam int N_RANDOM    = 435;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        req_t        req;
        logic [15:0] byte_cnt;
        logic [15:0] index;
        logic [31:0] base;
        logic [31:0] limit;
        logic [1:0]  contents;
        logic        rx_only;
        logic        d_b;
        logic        gran;
        logic        not_pres;
        logic        avl;
    } ldt_req_t;

    typedef struct {
        status_t             st;
        logic [DESC_W-1:0]   desc;
        logic [ENTRY_W-1:0]  entry;
        logic [15:0]         bytes;
        logic                last;
    } ldt_res_t;

    typedef struct {
        ldt_req_t    rq;
        bit          typed;
        status_t     t_st;
        logic [15:0] t_bytes;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]           s_axis_tuser = REQ_READ;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    logic [DESC_W-1:0] shadow_table [TABLE_ENTRIES];
    ldt_res_t          due_results [$];
    dir_row_t          dir_rows [$];
    int                n_bad = 0;
    int                burst_left = 0;
    int unsigned       cycles = 0;
    int unsigned       rx_tick = 0;
    int                stall_mode = 0;

    ldt_descriptor_table uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver back-pressure, with a stall mode picked at random
    always @(posedge aclk) begin
        if (rx_tick % 512 == 0) begin
            stall_mode = $urandom_range(0, 3);
        end
        rx_tick++;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ~(rx_tick[1] & rx_tick[3]);
            default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    function automatic logic [DESC_W-1:0] pack_desc(ldt_req_t r, bit legacy);
        logic avl_eff;
        avl_eff = legacy ? 1'b0 : r.avl;
        return {r.base[31:24], r.gran, r.d_b, 1'b0, avl_eff, r.limit[19:16], ~r.not_pres,
                2'b11, 1'b1, r.contents, ~r.rx_only, 1'b0, r.base[23:0], r.limit[15:0]};
    endfunction

    function automatic void ldt_apply_request(ldt_req_t r);
        int       want;
        int       avail;
        int       n;
        int       e;
        bit       legacy;
        bit       clr_ok;
        status_t  st;
        ldt_res_t res;
        case (r.req)
            REQ_READ: begin
                want  = (int'(r.byte_cnt) + 7) >> 3;
                if (want > MAX_READ) want = MAX_READ;
                avail = (int'(r.index) < TABLE_ENTRIES) ? TABLE_ENTRIES - int'(r.index) : 0;
                n     = (want < avail) ? want : avail;
                if (n == 0) begin
                    res = '{ST_OK, '0, r.index[ENTRY_W-1:0], 16'd0, 1'b1};
                    due_results.push_back(res);
                end
                for (int k = 0; k < n; k++) begin
                    e   = int'(r.index) + k;
                    res = '{ST_OK, shadow_table[e], ENTRY_W'(e), 16'((k + 1) * 8),
                            (k + 1 == n)};
                    due_results.push_back(res);
                end
            end
            REQ_WR_LEGACY, REQ_WR_EXT: begin
                legacy = (r.req == REQ_WR_LEGACY);
                st     = ST_OK;
                if (r.byte_cnt != WRITE_BYTES || int'(r.index) >= TABLE_ENTRIES) begin
                    st = ST_INVAL;
                end else if (r.contents == 2'd3 && (legacy || !r.not_pres)) begin
                    st = ST_INVAL;
                end else begin
                    clr_ok = legacy || (r.contents == 2'd0 && r.rx_only && !r.d_b &&
                                        !r.gran && r.not_pres && !r.avl);
                    if (r.base == 0 && r.limit == 0 && clr_ok) begin
                        shadow_table[r.index] = '0;
                    end else begin
                        shadow_table[r.index] = pack_desc(r, legacy);
                    end
                end
                res = '{st, '0, r.index[ENTRY_W-1:0], 16'd0, 1'b1};
                due_results.push_back(res);
            end
            default: begin
                res = '{ST_NOSYS, '0, r.index[ENTRY_W-1:0], 16'd0, 1'b1};
                due_results.push_back(res);
            end
        endcase
    endfunction

    always @(posedge aclk) begin : result_mon
        ldt_res_t got;
        ldt_res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{status_t'(m_axis_tuser), m_axis_tdata[63:0], m_axis_tdata[76:64],
                    m_axis_tdata[92:77], m_axis_tlast};
            if (due_results.size() == 0) begin
                n_bad++;
                if (n_bad <= REPORT_MAX) begin
                    $display("unexpected item: st=%0d desc=%h entry=%0d bytes=%0d last=%b",
                             got.st, got.desc, got.entry, got.bytes, got.last);
                end
            end else begin
                want = due_results.pop_front();
                if (got.st !== want.st || got.desc !== want.desc ||
                    got.entry !== want.entry || got.bytes !== want.bytes ||
                    got.last !== want.last) begin
                    n_bad++;
                    if (n_bad <= REPORT_MAX) begin
                        $display("mismatch exp: st=%0d desc=%h entry=%0d bytes=%0d last=%b",
                                 want.st, want.desc, want.entry, want.bytes, want.last);
                        $display("         got: st=%0d desc=%h entry=%0d bytes=%0d last=%b",
                                 got.st, got.desc, got.entry, got.bytes, got.last);
                    end
                end
            end
        end
    end

    task automatic send(input ldt_req_t r);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.req;
        s_axis_tdata  <= {1'b0, r.avl, r.not_pres, r.gran, r.d_b, r.rx_only, r.contents,
                          r.limit, r.base, r.index, r.byte_cnt};
        do @(posedge aclk); while (!s_axis_tready);
        ldt_apply_request(r);
        burst_left--;
    endtask

    // flags: {avl, not_pres, gran, d_b, rx_only}
    task automatic add_row(input req_t q, input logic [15:0] cnt, input logic [15:0] idx,
                           input logic [31:0] base, input logic [31:0] lim,
                           input logic [1:0] cont, input logic [4:0] flags,
                           input bit typed, input status_t st, input logic [15:0] bytes);
        dir_row_t row;
        row.rq = '{q, cnt, idx, base, lim, cont, flags[0], flags[1], flags[2], flags[3],
                   flags[4]};
        row.typed   = typed;
        row.t_st    = st;
        row.t_bytes = bytes;
        dir_rows.push_back(row);
    endtask

    function automatic ldt_req_t rand_req();
        ldt_req_t r;
        int       sel;
        r.base     = $urandom;
        r.limit    = $urandom;
        r.contents = 2'($urandom_range(0, 3));
        {r.avl, r.not_pres, r.gran, r.d_b, r.rx_only} = 5'($urandom_range(0, 31));
        r.index    = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(8064, 8191))
                                                 : 16'($urandom_range(0, 127));
        sel = $urandom_range(0, 99);
        if (sel < 42) begin
            r.req      = ($urandom_range(0, 1) != 0) ? REQ_WR_EXT : REQ_WR_LEGACY;
            r.byte_cnt = 16'(WRITE_BYTES);
            if ($urandom_range(0, 9) == 0) begin
                r.base  = '0;
                r.limit = '0;
                if ($urandom_range(0, 1) != 0) begin
                    r.contents = 2'd0;
                    {r.avl, r.not_pres, r.gran, r.d_b, r.rx_only} = 5'b01001;
                end
            end
            if ($urandom_range(0, 9) == 0) begin
                r.contents = 2'd3;
                r.not_pres = 1'b1;
            end
        end else if (sel < 78) begin
            r.req      = REQ_READ;
            r.byte_cnt = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 96));
        end else if (sel < 86) begin
            r.req      = REQ_READ;
            r.index    = 16'($urandom);
            r.byte_cnt = 16'($urandom);
        end else if (sel < 94) begin
            r.req = ($urandom_range(0, 1) != 0) ? REQ_WR_EXT : REQ_WR_LEGACY;
            if ($urandom_range(0, 1) != 0) begin
                r.byte_cnt = 16'($urandom);
            end else begin
                r.byte_cnt = 16'(WRITE_BYTES);
                r.index    = 16'($urandom);
            end
        end else begin
            r.req      = REQ_UNSUP;
            r.byte_cnt = 16'($urandom);
            r.index    = 16'($urandom);
        end
        return r;
    endfunction

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) shadow_table[i] = '0;

        add_row(REQ_READ,      16'd8,     16'd0,     '0, '0, 2'd0, 5'b00000, 1, ST_OK, 16'd8);
        add_row(REQ_READ,      16'hFFFF,  16'd8191,  '1, '1, 2'd3, 5'b11111, 1, ST_OK, 16'd8);
        add_row(REQ_READ,      16'd0,     16'd17,    '0, '0, 2'd0, 5'b00000, 1, ST_OK, 16'd0);
        add_row(REQ_READ,      16'd64,    16'd8192,  '0, '0, 2'd0, 5'b00000, 1, ST_OK, 16'd0);
        add_row(REQ_READ,      16'd16,    16'hFFFF,  '0, '0, 2'd0, 5'b00000, 1, ST_OK, 16'd0);
        add_row(REQ_UNSUP,     16'd16,    16'hA5A5,  '1, '1, 2'd1, 5'b10101, 1, ST_NOSYS, 16'd0);
        add_row(REQ_WR_LEGACY, 16'd15,    16'd4,     32'd1, 32'd1, 2'd0, 5'b00000,
                1, ST_INVAL, 16'd0);
        add_row(REQ_WR_EXT,    16'd17,    16'd4,     32'd1, 32'd1, 2'd0, 5'b00000,
                1, ST_INVAL, 16'd0);
        add_row(REQ_WR_LEGACY, 16'd16,    16'd8192,  32'd1, 32'd1, 2'd0, 5'b00000,
                1, ST_INVAL, 16'd0);
        add_row(REQ_WR_EXT,    16'd16,    16'hFFFF,  32'd1, 32'd1, 2'd0, 5'b00000,
                1, ST_INVAL, 16'd0);
        add_row(REQ_WR_LEGACY, 16'd16,    16'd6,     32'd9, 32'd9, 2'd3, 5'b01000,
                1, ST_INVAL, 16'd0);
        add_row(REQ_WR_EXT,    16'd16,    16'd6,     32'd9, 32'd9, 2'd3, 5'b00000,
                1, ST_INVAL, 16'd0);
        add_row(REQ_WR_EXT,    16'd16,    16'd5,     '1, '1, 2'd3, 5'b11111, 0, ST_OK, 16'd0);
        add_row(REQ_WR_LEGACY, 16'd16,    16'd0,     '1, '1, 2'd2, 5'b10111, 0, ST_OK, 16'd0);
        add_row(REQ_WR_LEGACY, 16'd16,    16'd7,     32'hDEAD_BEEF, 32'h0001_2345, 2'd0,
                5'b00000, 0, ST_OK, 16'd0);
        add_row(REQ_WR_LEGACY, 16'd16,    16'd7,     '0, '0, 2'd2, 5'b10110, 0, ST_OK, 16'd0);
        add_row(REQ_WR_EXT,    16'd16,    16'd8191,  '0, '0, 2'd0, 5'b11001, 0, ST_OK, 16'd0);
        add_row(REQ_WR_EXT,    16'd16,    16'd1,     '0, '0, 2'd0, 5'b01001, 0, ST_OK, 16'd0);
        add_row(REQ_WR_EXT,    16'd16,    16'd2,     32'h1234_5678, 32'hFFF0_ABCD, 2'd1,
                5'b00110, 0, ST_OK, 16'd0);
        add_row(REQ_WR_LEGACY, 16'd16,    16'd3,     32'h00FF_00FF, 32'h000F_0001, 2'd2,
                5'b10001, 0, ST_OK, 16'd0);
        add_row(REQ_READ,      16'd512,   16'd0,     '0, '0, 2'd0, 5'b00000, 0, ST_OK, 16'd0);
        add_row(REQ_READ,      16'd24,    16'd8190,  '0, '0, 2'd0, 5'b00000, 0, ST_OK, 16'd0);
        add_row(REQ_READ,      16'd513,   16'd0,     '0, '0, 2'd0, 5'b00000, 0, ST_OK, 16'd0);
        add_row(REQ_WR_EXT,    16'd16,    16'd8191,  '0, '0, 2'd0, 5'b01001, 0, ST_OK, 16'd0);
        add_row(REQ_READ,      16'd9,     16'd8190,  '0, '0, 2'd0, 5'b00000, 0, ST_OK, 16'd0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send(dir_rows[i].rq);
            if (dir_rows[i].typed) begin
                due_results[due_results.size() - 1] =
                    '{dir_rows[i].t_st, '0, dir_rows[i].rq.index[ENTRY_W-1:0],
                      dir_rows[i].t_bytes, 1'b1};
            end
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            send(rand_req());
        end
        s_axis_tvalid <= 1'b0;

        while (due_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (n_bad == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
